// File: hw/rtl/baro_pkg.sv
// ----------------------------------------------------------------------------
// Barometer compensation package
// Shared types, register indexes and constants of the compensation block.
// ----------------------------------------------------------------------------
package baro_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_AC1   = 3'd0;
    localparam logic [2:0] REG_AC2   = 3'd1;
    localparam logic [2:0] REG_AC3   = 3'd2;
    localparam logic [2:0] REG_AC4   = 3'd3;
    localparam logic [2:0] REG_AC5   = 3'd4;
    localparam logic [2:0] REG_AC6   = 3'd5;
    localparam logic [2:0] REG_B1_B2 = 3'd6;
    localparam logic [2:0] REG_MC_MD = 3'd7;

    localparam int unsigned CFG_INDEX_W = 8;

    // Item opcodes
    localparam logic OP_TEMP = 1'b0;
    localparam logic OP_PRES = 1'b1;

    // Divider control and status
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } div_rsp_t;

endpackage

// File: hw/rtl/barometer_raw_compensation_top.sv
// ----------------------------------------------------------------------------
// Barometer raw compensation top level
// Converts raw temperature and pressure readings into calibrated values.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, opcode, raw_reading) takes one word
// per item; opcode 0 is a raw temperature, 1 a raw pressure. The output
// channel (out_valid, out_stall, kind, value, div_error) returns one word per
// item. Calibration registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data, while the block is idle.
// A sequencer drives one shared 32x32 multiplier and a serial divider; the
// divider wait dominates each item. The next item is accepted in the cycle
// after the result reaches the output register, so the block takes no new
// item before the last one is through. in_stall is high while an item is in
// work or its result still waits. A stalled result holds in the output
// register. Reset clears the calibration registers, the stored temperature
// intermediate, and empties the output register.
// ----------------------------------------------------------------------------
module barometer_raw_compensation_top
    import baro_pkg::*;
#(
    parameter int unsigned OVERSAMPLING = 0
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   opcode,
    input  logic [18:0]            raw_reading,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   kind,
    output logic signed [31:0]     value,
    output logic                   div_error,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    localparam logic [1:0]  OSS      = OVERSAMPLING[1:0];
    localparam logic [31:0] B7_SCALE = 32'd50000 >> OSS;

    typedef enum logic [4:0] {
        S_IDLE, S_T1, S_T2, S_T3, S_TDIV, S_TEND,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
        S_PDIV, S_P10, S_P11, S_P12, S_P13, S_OUT
    } state_t;

    state_t      state_reg;
    logic [15:0] ac1_reg, ac2_reg, ac3_reg, ac4_reg, ac5_reg, ac6_reg;
    logic [31:0] b1b2_reg, mcmd_reg;
    logic [31:0] b5_reg;
    logic        op_reg;
    logic [18:0] raw_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, p_reg;
    logic        neg_reg, big_reg;
    logic        out_valid_reg, kind_reg, err_reg, div_error_reg;
    logic [31:0] value_reg;
    div_req_t    dreq;
    div_rsp_t    drsp;

    // Shared multiplier operands and product
    logic [31:0] mul_a, mul_b, prod;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
        asr = 32'($signed(v) >>> s);
    endfunction

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_T1:  begin mul_a = {16'd0, raw_reg[15:0]} - {16'd0, ac6_reg};
                         mul_b = {16'd0, ac5_reg}; end
            S_P1:  begin mul_a = b5_reg - 32'd4000; mul_b = b5_reg - 32'd4000; end
            S_P2:  begin mul_a = sx16(b1b2_reg[15:0]); mul_b = a_reg; end
            S_P3:  begin mul_a = sx16(ac2_reg); mul_b = b_reg; end
            S_P4:  begin mul_a = sx16(ac3_reg); mul_b = b_reg; end
            S_P5:  begin mul_a = sx16(b1b2_reg[31:16]); mul_b = a_reg; end
            S_P7:  begin mul_a = {16'd0, ac4_reg}; mul_b = c_reg + 32'd32768; end
            S_P8:  begin mul_a = {13'd0, raw_reg} - d_reg; mul_b = B7_SCALE; end
            S_P10: begin mul_a = asr(p_reg, 5'd8); mul_b = asr(p_reg, 5'd8); end
            S_P11: begin mul_a = a_reg; mul_b = 32'd3038; end
            S_P12: begin mul_a = 32'd0 - 32'd7357; mul_b = p_reg; end
            default: ;
        endcase
    end
    assign prod = mul_a * mul_b;

    // The temperature division runs on magnitudes; the sign is restored after.
    assign dreq.start = ((state_reg == S_T3) || (state_reg == S_P9)) && (b_reg != '0);
    assign dreq.num   = (state_reg == S_T3 && a_reg[31]) ? 32'd0 - a_reg : a_reg;
    assign dreq.den   = (state_reg == S_T3 && b_reg[31]) ? 32'd0 - b_reg : b_reg;

    baro_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // Configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac1_reg <= '0; ac2_reg <= '0; ac3_reg <= '0;
            ac4_reg <= '0; ac5_reg <= '0; ac6_reg <= '0;
            b1b2_reg <= '0; mcmd_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                8'(REG_AC1):   ac1_reg  <= cfg_data[15:0];
                8'(REG_AC2):   ac2_reg  <= cfg_data[15:0];
                8'(REG_AC3):   ac3_reg  <= cfg_data[15:0];
                8'(REG_AC4):   ac4_reg  <= cfg_data[15:0];
                8'(REG_AC5):   ac5_reg  <= cfg_data[15:0];
                8'(REG_AC6):   ac6_reg  <= cfg_data[15:0];
                8'(REG_B1_B2): b1b2_reg <= cfg_data;
                8'(REG_MC_MD): mcmd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer with datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            b5_reg        <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= 1'b0;
            raw_reg       <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            e_reg         <= '0;
            p_reg         <= '0;
            neg_reg       <= 1'b0;
            big_reg       <= 1'b0;
            kind_reg      <= 1'b0;
            err_reg       <= 1'b0;
            div_error_reg <= 1'b0;
            value_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_valid && !in_stall)
                    begin
                        op_reg    <= opcode;
                        raw_reg   <= raw_reading;
                        state_reg <= (opcode == OP_TEMP) ? S_T1 : S_P1;
                    end
                // x1 and the divisor
                S_T1:
                begin
                    a_reg     <= asr(prod, 5'd15);
                    state_reg <= S_T2;
                end
                S_T2:
                begin
                    c_reg     <= a_reg;
                    b_reg     <= a_reg + sx16(mcmd_reg[15:0]);
                    a_reg     <= sx16(mcmd_reg[31:16]) << 11;
                    state_reg <= S_T3;
                end
                S_T3:
                begin
                    if (b_reg == '0)
                    begin
                        err_reg   <= 1'b1;
                        p_reg     <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        neg_reg   <= a_reg[31] ^ b_reg[31];
                        state_reg <= S_TDIV;
                    end
                end
                S_TDIV:
                    if (drsp.done)
                    begin
                        a_reg     <= neg_reg ? 32'd0 - drsp.quo : drsp.quo;
                        state_reg <= S_TEND;
                    end
                S_TEND:
                begin
                    b5_reg    <= c_reg + a_reg;
                    p_reg     <= asr(c_reg + a_reg + 32'd8, 5'd4);
                    err_reg   <= 1'b0;
                    state_reg <= S_OUT;
                end
                // Pressure: sq and b6
                S_P1:
                begin
                    a_reg     <= asr(prod, 5'd12);
                    b_reg     <= b5_reg - 32'd4000;
                    state_reg <= S_P2;
                end
                S_P2:
                begin
                    c_reg     <= asr(prod, 5'd11);
                    state_reg <= S_P3;
                end
                S_P3:
                begin
                    e_reg     <= asr((((sx16(ac1_reg) << 2) + c_reg + asr(prod, 5'd11))
                                      << OSS) + 32'd2, 5'd2);
                    state_reg <= S_P4;
                end
                S_P4:
                begin
                    c_reg     <= asr(prod, 5'd13);
                    state_reg <= S_P5;
                end
                S_P5:
                begin
                    c_reg     <= c_reg + asr(prod, 5'd16);
                    state_reg <= S_P6;
                end
                S_P6:
                begin
                    c_reg     <= asr(c_reg + 32'd2, 5'd2);
                    state_reg <= S_P7;
                end
                S_P7:
                begin
                    b_reg     <= prod >> 15;
                    d_reg     <= e_reg;
                    state_reg <= S_P8;
                end
                S_P8:
                begin
                    big_reg   <= prod[31];
                    a_reg     <= prod[31] ? prod : prod << 1;
                    state_reg <= S_P9;
                end
                S_P9:
                begin
                    if (b_reg == '0)
                    begin
                        err_reg   <= 1'b1;
                        p_reg     <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_PDIV;
                end
                S_PDIV:
                    if (drsp.done)
                    begin
                        p_reg     <= big_reg ? drsp.quo << 1 : drsp.quo;
                        state_reg <= S_P10;
                    end
                S_P10:
                begin
                    a_reg     <= prod;
                    state_reg <= S_P11;
                end
                S_P11:
                begin
                    c_reg     <= asr(prod, 5'd16);
                    state_reg <= S_P12;
                end
                S_P12:
                begin
                    c_reg     <= c_reg + asr(prod, 5'd16) + 32'd3791;
                    state_reg <= S_P13;
                end
                S_P13:
                begin
                    p_reg     <= p_reg + asr(c_reg, 5'd4);
                    err_reg   <= 1'b0;
                    state_reg <= S_OUT;
                end
                // Hand the result word to the output register
                S_OUT:
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= op_reg;
                        value_reg     <= p_reg;
                        div_error_reg <= err_reg;
                        state_reg     <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;
    assign div_error = div_error_reg;

`ifndef SYNTHESIS
    // A result only appears after the sequencer hands it over
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_OUT)
        else $error("result without handover");

    // The divider only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> (state_reg == S_TDIV || state_reg == S_PDIV))
        else $error("divider finished out of step");

    // A zero-divisor result carries value zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && div_error) |-> value == 32'sd0)
        else $error("error result with nonzero value");
`endif

endmodule

// File: hw/rtl/baro_div.sv
// ----------------------------------------------------------------------------
// Barometer serial divider
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module baro_div
    import baro_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] diff;

    // One shift and subtract step per cycle
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]};
        diff      = trial - {1'b0, den_reg};
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule
